// ----- design/lpr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and codes for the line pixel rasterizer: request and result
// payloads, command and status codes, and the stepping direction flags.
// ----------------------------------------------------------------------------
package lpr_pkg;

    // Fixed payload widths
    localparam int unsigned IN_COORD_W = 16;
    localparam int unsigned PIX_W      = 12;
    localparam int unsigned COLOR_W    = 16;

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REJECT  = 2'd1,
        STATUS_NO_LINE = 2'd2
    } t_status;

    // Stepping direction and major axis of the active line
    typedef struct packed {
        logic y_major;
        logic y_neg;
        logic x_neg;
    } t_axis;

    typedef struct packed {
        t_cmd                  cmd;
        logic [IN_COORD_W-1:0] start_x;
        logic [IN_COORD_W-1:0] start_y;
        logic [IN_COORD_W-1:0] end_x;
        logic [IN_COORD_W-1:0] end_y;
        logic [COLOR_W-1:0]    ink;
    } t_lpr_in;

    typedef struct packed {
        t_status            status;
        logic               pixel_valid;
        logic [PIX_W-1:0]   pixel_x;
        logic [PIX_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } t_lpr_out;

endpackage

// ----- design/lpr_setup.sv -----
// ----------------------------------------------------------------------------
// lpr_setup
// Line setup for a start request: screen bounds check, first pixel, major
// axis end, direction flags, initial decision term and its two increments.
// ----------------------------------------------------------------------------
module lpr_setup
    import lpr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int COORD_W       = 9,
    parameter int DEC_W         = 12
) (
    input  t_lpr_in                   i_req,
    output logic                      o_on_screen,
    output logic [COORD_W-1:0]        o_col,
    output logic [COORD_W-1:0]        o_row,
    output logic [COORD_W-1:0]        o_major_end,
    output t_axis                     o_axis,
    output logic signed [DEC_W-1:0]   o_decision,
    output logic signed [DEC_W-1:0]   o_inc_lt,
    output logic signed [DEC_W-1:0]   o_inc_ge
);

    localparam logic [IN_COORD_W-1:0] WIDTH_LIM  = IN_COORD_W'(SCREEN_WIDTH);
    localparam logic [IN_COORD_W-1:0] HEIGHT_LIM = IN_COORD_W'(SCREEN_HEIGHT);
    localparam int unsigned           PAD_W      = DEC_W - COORD_W;

    logic [COORD_W-1:0]      x0, y0, x1, y1;
    logic                    x_eq, y_eq, x_lt, y_lt;
    logic [COORD_W-1:0]      adx, ady, dmaj, dmin;
    logic                    y_major;
    logic signed [DEC_W-1:0] dmaj_s, dmin_s;

    // Check all four coordinates against the screen
    assign o_on_screen = (i_req.start_x < WIDTH_LIM) && (i_req.end_x < WIDTH_LIM) &&
                         (i_req.start_y < HEIGHT_LIM) && (i_req.end_y < HEIGHT_LIM);

    always_comb begin
        x0 = i_req.start_x[COORD_W-1:0];
        y0 = i_req.start_y[COORD_W-1:0];
        x1 = i_req.end_x[COORD_W-1:0];
        y1 = i_req.end_y[COORD_W-1:0];

        x_eq = (x0 == x1);
        y_eq = (y0 == y1);
        x_lt = (x1 < x0);
        y_lt = (y1 < y0);

        // Absolute deltas; zero on an axis-aligned run's minor axis
        adx = x_lt ? (x0 - x1) : (x1 - x0);
        ady = y_lt ? (y0 - y1) : (y1 - y0);

        // Vertical runs and single points step along y
        y_major = x_eq || (adx < ady);

        o_axis.y_major = y_major;
        o_axis.y_neg   = !x_eq && y_lt;
        o_axis.x_neg   = !x_eq && !y_eq && x_lt;

        // Axis runs start at the smaller coordinate
        o_col = (!x_eq && y_eq && x_lt) ? x1 : x0;
        o_row = (x_eq && y_lt) ? y1 : y0;

        if (x_eq) begin
            o_major_end = y_lt ? y0 : y1;
        end else if (y_eq) begin
            o_major_end = x_lt ? x0 : x1;
        end else begin
            o_major_end = y_major ? y1 : x1;
        end

        dmaj = y_major ? ady : adx;
        dmin = y_major ? adx : ady;

        // Decision term and its per-step increments
        dmaj_s     = $signed({{PAD_W{1'b0}}, dmaj});
        dmin_s     = $signed({{PAD_W{1'b0}}, dmin});
        o_decision = (dmin_s <<< 1) - dmaj_s;
        o_inc_lt   = dmin_s <<< 1;
        o_inc_ge   = (dmin_s <<< 1) - (dmaj_s <<< 1);
    end

endmodule

// ----- design/line_pixel_rasterizer_unit.sv -----
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_unit
// Integer Bresenham line rasterizer driven by start and step requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one request per
//   cycle. A start request loads two endpoints and a color; it is rejected
//   when any coordinate is off screen, and always abandons a line in
//   progress. A step request emits the next pixel of the active line, with
//   last set on the final one, or reports that no line is active.
//   Output channel (o_out_valid / i_out_ready / o_out_data) returns exactly
//   one result per request, in order.
//   Latency: the result is valid the cycle after its request is accepted.
//   Throughput: one request per cycle while the receiver takes results; each
//   step is a single add of the decision term and a compare against the
//   major axis end, held in registers between requests.
//   Backpressure: the single output register accepts a new request in the
//   same cycle its held result is taken (o_in_ready = !o_out_valid ||
//   i_out_ready); while the receiver stalls, the result holds and no request
//   is taken.
//   Reset (synchronous, active low) clears the active line and empties the
//   output register.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_unit
    import lpr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_lpr_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_lpr_out o_out_data
);

    localparam int MAX_DIM = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int COORD_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEC_W   = COORD_W + 3;

    // Line state
    logic                    r_active, n_active;
    logic [COORD_W-1:0]      r_col, n_col;
    logic [COORD_W-1:0]      r_row, n_row;
    logic [COORD_W-1:0]      r_major_end, n_major_end;
    t_axis                   r_axis, n_axis;
    logic signed [DEC_W-1:0] r_decision, n_decision;
    logic signed [DEC_W-1:0] r_inc_lt, n_inc_lt;
    logic signed [DEC_W-1:0] r_inc_ge, n_inc_ge;
    logic [COLOR_W-1:0]      r_color, n_color;

    // Result register
    logic                    r_out_valid, n_out_valid;
    t_lpr_out                r_out_data, n_out_data;

    // Setup results
    logic                    s_on_screen;
    logic [COORD_W-1:0]      s_col, s_row, s_major_end;
    t_axis                   s_axis;
    logic signed [DEC_W-1:0] s_decision, s_inc_lt, s_inc_ge;

    logic                    w_accept;
    logic [COORD_W-1:0]      w_major_pos;
    logic                    w_last;
    logic [COORD_W-1:0]      w_col_step, w_row_step;

    lpr_setup #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .COORD_W       (COORD_W),
        .DEC_W         (DEC_W)
    ) u_setup (
        .i_req       (i_in_data),
        .o_on_screen (s_on_screen),
        .o_col       (s_col),
        .o_row       (s_row),
        .o_major_end (s_major_end),
        .o_axis      (s_axis),
        .o_decision  (s_decision),
        .o_inc_lt    (s_inc_lt),
        .o_inc_ge    (s_inc_ge)
    );

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Current position on the major axis and the neighbors one step away
    assign w_major_pos = r_axis.y_major ? r_row : r_col;
    assign w_last      = (w_major_pos == r_major_end);
    assign w_col_step  = r_axis.x_neg ? (r_col - 1'b1) : (r_col + 1'b1);
    assign w_row_step  = r_axis.y_neg ? (r_row - 1'b1) : (r_row + 1'b1);

    // Next state and result for the accepted request
    always_comb begin
        n_active    = r_active;
        n_col       = r_col;
        n_row       = r_row;
        n_major_end = r_major_end;
        n_axis      = r_axis;
        n_decision  = r_decision;
        n_inc_lt    = r_inc_lt;
        n_inc_ge    = r_inc_ge;
        n_color     = r_color;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;

        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            case (i_in_data.cmd)
                CMD_START: begin
                    if (s_on_screen) begin
                        n_active          = 1'b1;
                        n_col             = s_col;
                        n_row             = s_row;
                        n_major_end       = s_major_end;
                        n_axis            = s_axis;
                        n_decision        = s_decision;
                        n_inc_lt          = s_inc_lt;
                        n_inc_ge          = s_inc_ge;
                        n_color           = i_in_data.ink;
                        n_out_data.status = STATUS_OK;
                    end else begin
                        n_active          = 1'b0;
                        n_out_data.status = STATUS_REJECT;
                    end
                end
                CMD_STEP: begin
                    if (!r_active) begin
                        n_out_data.status = STATUS_NO_LINE;
                    end else begin
                        n_out_data.status      = STATUS_OK;
                        n_out_data.pixel_valid = 1'b1;
                        n_out_data.pixel_x     = PIX_W'(r_col);
                        n_out_data.pixel_y     = PIX_W'(r_row);
                        n_out_data.pixel_color = r_color;
                        n_out_data.last        = w_last;
                        if (w_last) begin
                            n_active = 1'b0;
                        end else begin
                            // Advance the major axis; step the minor when the term allows
                            if (r_axis.y_major) begin
                                n_row = w_row_step;
                            end else begin
                                n_col = w_col_step;
                            end
                            if (r_decision[DEC_W-1]) begin
                                n_decision = r_decision + r_inc_lt;
                            end else begin
                                n_decision = r_decision + r_inc_ge;
                                if (r_axis.y_major) begin
                                    n_col = w_col_step;
                                end else begin
                                    n_row = w_row_step;
                                end
                            end
                        end
                    end
                end
                default: begin
                    n_out_data.status = STATUS_NO_LINE;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    // Line and result payload
    always_ff @(posedge i_clk) begin
        r_col       <= n_col;
        r_row       <= n_row;
        r_major_end <= n_major_end;
        r_axis      <= n_axis;
        r_decision  <= n_decision;
        r_inc_lt    <= n_inc_lt;
        r_inc_ge    <= n_inc_ge;
        r_color     <= n_color;
        r_out_data  <= n_out_data;
    end

`ifndef SYNTHESIS
    // A pixel result always reports success
    a_pixel_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pixel_valid |-> o_out_data.status == STATUS_OK)
        else $error("pixel result with non-ok status");

    // A result without a pixel carries no last flag and zero coordinates
    a_no_pixel_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pixel_valid |->
        !o_out_data.last && o_out_data.pixel_x == '0 && o_out_data.pixel_y == '0)
        else $error("non-pixel result carries pixel fields");

    // Emitted pixels stay on screen
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pixel_valid |->
        o_out_data.pixel_x < PIX_W'(SCREEN_WIDTH) && o_out_data.pixel_y < PIX_W'(SCREEN_HEIGHT)
        || SCREEN_WIDTH == 4096 || SCREEN_HEIGHT == 4096)
        else $error("pixel off screen");

    // The final pixel ends the line
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_data.cmd == CMD_STEP && r_active && w_last |=> !r_active)
        else $error("line still active after last pixel");

    // An on-screen start opens a line and reports success
    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_data.cmd == CMD_START && s_on_screen |=>
        r_active && o_out_valid && o_out_data.status == STATUS_OK)
        else $error("accepted start did not open a line");
`endif

endmodule
